>>> hdl/qasmm_pkg.sv
// Shared types, register codes and constants of the quad arming and motor mixer.
`timescale 1ns / 1ps

package qasmm_pkg;

    // Stick thresholds in microseconds.
    localparam logic [11:0] STICK_HI  = 12'd1508;
    localparam logic [11:0] STICK_LO  = 12'd1492;
    localparam logic [11:0] THR_LOW   = 12'd1050;
    localparam logic [11:0] YAW_PRIME = 12'd1300;
    localparam logic [11:0] YAW_ARM   = 12'd1450;
    localparam logic [11:0] YAW_STOP  = 12'd1700;

    // ceil(2^25 / 3): exact floor division by three for magnitudes below 2^24.
    localparam int          DIV3_SHIFT = 25;
    localparam logic [23:0] DIV3_RECIP = 24'd11184811;

    // Configuration register indexes.
    localparam logic [2:0] CFG_AUTO_LEVEL_ON = 3'd0;
    localparam logic [2:0] CFG_LEVEL_GAIN    = 3'd1;
    localparam logic [2:0] CFG_THROTTLE_CAP  = 3'd2;
    localparam logic [2:0] CFG_ESC_RUN_MIN   = 3'd3;
    localparam logic [2:0] CFG_ESC_RUN_MAX   = 3'd4;
    localparam logic [2:0] CFG_ESC_OFF_PULSE = 3'd5;

    // Configuration reset values.
    localparam logic        RST_AUTO_LEVEL_ON = 1'b1;
    localparam logic [7:0]  RST_LEVEL_GAIN    = 8'd15;
    localparam logic [11:0] RST_THROTTLE_CAP  = 12'd1800;
    localparam logic [11:0] RST_ESC_RUN_MIN   = 12'd1100;
    localparam logic [11:0] RST_ESC_RUN_MAX   = 12'd2000;
    localparam logic [11:0] RST_ESC_OFF_PULSE = 12'd1000;

    localparam logic FUNC_SETPOINT = 1'b0;
    localparam logic FUNC_MIX      = 1'b1;

    typedef enum logic [1:0] {
        ARM_STOPPED = 2'd0,
        ARM_PRIMED  = 2'd1,
        ARM_RUNNING = 2'd2
    } arm_state_t;

    typedef struct packed {
        logic        auto_level_on;
        logic [7:0]  level_gain;
        logic [11:0] throttle_cap;
        logic [11:0] esc_run_min;
        logic [11:0] esc_run_max;
        logic [11:0] esc_off_pulse;
    } cfg_t;

    typedef struct packed {
        arm_state_t current;
        arm_state_t updated;
        logic       armed;
    } arm_status_t;

    typedef struct packed {
        logic               func;
        logic [11:0]        rx_roll;
        logic [11:0]        rx_pitch;
        logic [11:0]        rx_throttle;
        logic [11:0]        rx_yaw;
        logic signed [15:0] angle_roll_in;
        logic signed [15:0] angle_pitch_in;
        logic signed [11:0] pid_roll_out;
        logic signed [11:0] pid_pitch_out;
        logic signed [11:0] pid_yaw_out;
    } item_t;

    typedef struct packed {
        logic signed [19:0] setpoint_roll;
        logic signed [19:0] setpoint_pitch;
        logic signed [15:0] setpoint_yaw;
        logic [1:0]         arm_state_out;
        logic               reset_request;
        logic [11:0]        esc_front_right;
        logic [11:0]        esc_rear_right;
        logic [11:0]        esc_rear_left;
        logic [11:0]        esc_front_left;
    } result_t;

endpackage

>>> hdl/qasmm_if.sv
// Valid/ready channel interfaces for input items and result items.
`timescale 1ns / 1ps

interface qasmm_item_if;
    logic              valid;
    logic              ready;
    qasmm_pkg::item_t  data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface qasmm_result_if;
    logic               valid;
    logic               ready;
    qasmm_pkg::result_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> hdl/qasmm_cfg_regs.sv
// Configuration register file written through a plain write port.
`timescale 1ns / 1ps

module qasmm_cfg_regs (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wen,
    input  logic [2:0]          cfg_index,
    input  logic [11:0]         cfg_data,
    output qasmm_pkg::cfg_t     cfg
);

    qasmm_pkg::cfg_t cfg_reg;
    qasmm_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wen)
        begin
            unique case (cfg_index)
                qasmm_pkg::CFG_AUTO_LEVEL_ON: cfg_next.auto_level_on = cfg_data[0];
                qasmm_pkg::CFG_LEVEL_GAIN:    cfg_next.level_gain    = cfg_data[7:0];
                qasmm_pkg::CFG_THROTTLE_CAP:  cfg_next.throttle_cap  = cfg_data;
                qasmm_pkg::CFG_ESC_RUN_MIN:   cfg_next.esc_run_min   = cfg_data;
                qasmm_pkg::CFG_ESC_RUN_MAX:   cfg_next.esc_run_max   = cfg_data;
                qasmm_pkg::CFG_ESC_OFF_PULSE: cfg_next.esc_off_pulse = cfg_data;
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.auto_level_on <= qasmm_pkg::RST_AUTO_LEVEL_ON;
            cfg_reg.level_gain    <= qasmm_pkg::RST_LEVEL_GAIN;
            cfg_reg.throttle_cap  <= qasmm_pkg::RST_THROTTLE_CAP;
            cfg_reg.esc_run_min   <= qasmm_pkg::RST_ESC_RUN_MIN;
            cfg_reg.esc_run_max   <= qasmm_pkg::RST_ESC_RUN_MAX;
            cfg_reg.esc_off_pulse <= qasmm_pkg::RST_ESC_OFF_PULSE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> hdl/qasmm_arming.sv
// Stick-arming state machine: stopped, primed, running.
`timescale 1ns / 1ps

module qasmm_arming (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    step,
    input  logic [11:0]             rx_throttle,
    input  logic [11:0]             rx_yaw,
    output qasmm_pkg::arm_status_t  status
);

    qasmm_pkg::arm_state_t state_reg;
    qasmm_pkg::arm_state_t state_next;

    logic thr_low;
    logic yaw_prime;
    logic yaw_arm;
    logic yaw_stop;

    assign thr_low   = rx_throttle < qasmm_pkg::THR_LOW;
    assign yaw_prime = rx_yaw < qasmm_pkg::YAW_PRIME;
    assign yaw_arm   = rx_yaw > qasmm_pkg::YAW_ARM;
    assign yaw_stop  = rx_yaw > qasmm_pkg::YAW_STOP;

    // A primed machine that sees a stop-level yaw goes straight to stopped, with armed raised.
    always_comb
    begin
        state_next = state_reg;
        if (thr_low && yaw_prime)
        begin
            state_next = qasmm_pkg::ARM_PRIMED;
        end
        else if (thr_low)
        begin
            unique case (state_reg)
                qasmm_pkg::ARM_PRIMED:
                begin
                    if (yaw_stop)
                        state_next = qasmm_pkg::ARM_STOPPED;
                    else if (yaw_arm)
                        state_next = qasmm_pkg::ARM_RUNNING;
                end
                qasmm_pkg::ARM_RUNNING:
                begin
                    if (yaw_stop)
                        state_next = qasmm_pkg::ARM_STOPPED;
                end
                qasmm_pkg::ARM_STOPPED: state_next = state_reg;
                default:                state_next = qasmm_pkg::ARM_STOPPED;
            endcase
        end
    end

    always_comb
    begin
        status.current = state_reg;
        status.updated = state_next;
        status.armed   = (state_reg == qasmm_pkg::ARM_PRIMED) && thr_low && yaw_arm;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= qasmm_pkg::ARM_STOPPED;
        else if (step)
            state_reg <= state_next;
    end

endmodule

>>> hdl/qasmm_setpoint.sv
// Rate setpoints: stick deadband, level correction, division by three, saturation.
`timescale 1ns / 1ps

module qasmm_setpoint (
    input  logic [11:0]        rx_roll,
    input  logic [11:0]        rx_pitch,
    input  logic [11:0]        rx_throttle,
    input  logic [11:0]        rx_yaw,
    input  logic signed [23:0] adj_roll,
    input  logic signed [23:0] adj_pitch,
    output logic signed [19:0] setpoint_roll,
    output logic signed [19:0] setpoint_pitch,
    output logic signed [15:0] setpoint_yaw
);

    localparam logic signed [23:0] SP_MAX = 24'sd524287;
    localparam logic signed [23:0] SP_MIN = -24'sd524288;

    // Stick offset outside the deadband, scaled to 4 fractional bits.
    function automatic logic signed [25:0] stick_term(input logic [11:0] x);
        logic signed [13:0] xs;
        logic signed [13:0] d;
        begin
            xs = $signed({2'b00, x});
            if (x > qasmm_pkg::STICK_HI)
                d = xs - $signed({2'b00, qasmm_pkg::STICK_HI});
            else if (x < qasmm_pkg::STICK_LO)
                d = xs - $signed({2'b00, qasmm_pkg::STICK_LO});
            else
                d = '0;
            return {{8{d[13]}}, d, 4'b0000};
        end
    endfunction

    // Division by three toward zero; magnitudes here stay below 2^24.
    function automatic logic signed [23:0] div3(input logic signed [25:0] n);
        logic [25:0] mag;
        logic [47:0] prod;
        logic [23:0] q;
        begin
            mag  = n[25] ? 26'(-n) : 26'(n);
            prod = 48'(mag[23:0]) * 48'(qasmm_pkg::DIV3_RECIP);
            q    = {1'b0, prod[qasmm_pkg::DIV3_SHIFT +: 23]};
            return n[25] ? $signed(24'(-q)) : $signed(q);
        end
    endfunction

    function automatic logic signed [19:0] sat20(input logic signed [23:0] v);
        begin
            if (v > SP_MAX)
                return SP_MAX[19:0];
            else if (v < SP_MIN)
                return SP_MIN[19:0];
            else
                return v[19:0];
        end
    endfunction

    logic signed [25:0] sum_roll;
    logic signed [25:0] sum_pitch;
    logic signed [25:0] sum_yaw;
    logic signed [23:0] q_yaw;

    assign sum_roll  = stick_term(rx_roll) - 26'(adj_roll);
    assign sum_pitch = -stick_term(rx_pitch) - 26'(adj_pitch);
    assign sum_yaw   = (rx_throttle > qasmm_pkg::THR_LOW) ? stick_term(rx_yaw) : '0;

    assign setpoint_roll  = sat20(div3(sum_roll));
    assign setpoint_pitch = sat20(div3(sum_pitch));

    // The yaw stick alone cannot leave the 16-bit range.
    assign q_yaw        = div3(sum_yaw);
    assign setpoint_yaw = q_yaw[15:0];

endmodule

>>> hdl/qasmm_mixer.sv
// X-layout motor mixer with throttle cap and running clamps.
`timescale 1ns / 1ps

module qasmm_mixer (
    input  qasmm_pkg::cfg_t    cfg,
    input  logic               running,
    input  logic [11:0]        rx_throttle,
    input  logic signed [11:0] pid_roll_out,
    input  logic signed [11:0] pid_pitch_out,
    input  logic signed [11:0] pid_yaw_out,
    output logic [11:0]        esc_front_right,
    output logic [11:0]        esc_rear_right,
    output logic [11:0]        esc_rear_left,
    output logic [11:0]        esc_front_left
);

    // Raise to the run minimum first, then lower to the run maximum.
    function automatic logic [11:0] clamp(input logic signed [14:0] v,
                                          input logic [11:0] lo,
                                          input logic [11:0] hi);
        logic signed [14:0] r;
        begin
            r = v;
            if (r < $signed({3'b000, lo}))
                r = $signed({3'b000, lo});
            if (r > $signed({3'b000, hi}))
                r = $signed({3'b000, hi});
            return r[11:0];
        end
    endfunction

    logic [11:0]        base;
    logic signed [14:0] b;
    logic signed [14:0] r;
    logic signed [14:0] p;
    logic signed [14:0] y;
    logic signed [14:0] sum_fr;
    logic signed [14:0] sum_rr;
    logic signed [14:0] sum_rl;
    logic signed [14:0] sum_fl;

    assign base = (rx_throttle > cfg.throttle_cap) ? cfg.throttle_cap : rx_throttle;
    assign b    = $signed({3'b000, base});
    assign r    = 15'(pid_roll_out);
    assign p    = 15'(pid_pitch_out);
    assign y    = 15'(pid_yaw_out);

    assign sum_fr = b - p + r - y;
    assign sum_rr = b + p + r + y;
    assign sum_rl = b + p - r - y;
    assign sum_fl = b - p - r + y;

    always_comb
    begin
        if (running)
        begin
            esc_front_right = clamp(sum_fr, cfg.esc_run_min, cfg.esc_run_max);
            esc_rear_right  = clamp(sum_rr, cfg.esc_run_min, cfg.esc_run_max);
            esc_rear_left   = clamp(sum_rl, cfg.esc_run_min, cfg.esc_run_max);
            esc_front_left  = clamp(sum_fl, cfg.esc_run_min, cfg.esc_run_max);
        end
        else
        begin
            esc_front_right = cfg.esc_off_pulse;
            esc_rear_right  = cfg.esc_off_pulse;
            esc_rear_left   = cfg.esc_off_pulse;
            esc_front_left  = cfg.esc_off_pulse;
        end
    end

endmodule

>>> hdl/quad_arming_setpoint_motor_mixer.sv
// Top level: input register, arming, setpoint and mixer logic, result register.
//
//  Channel  Dir  Transfer on            Payload
//  item     in   item.valid & ready     qasmm_pkg::item_t
//  result   out  result.valid & ready   qasmm_pkg::result_t
//  cfg      in   cfg_wen                cfg_index (3 bits), cfg_data (12 bits)
//
// Each item passes the input register, then the result register; one item per
// cycle is sustained while results are taken. The level products are formed on
// the way into the input register; the division by three and the mix sit before
// the result register. Reset clears both valid flags and the arming state, and
// loads the configuration reset values. A stalled result holds both stages; the
// input register drains into the result register when the result is taken.
`timescale 1ns / 1ps

module quad_arming_setpoint_motor_mixer (
    input  logic                 clk,
    input  logic                 rst_n,
    qasmm_item_if.sink           item,
    qasmm_result_if.source       result,
    input  logic                 cfg_wen,
    input  logic [2:0]           cfg_index,
    input  logic [11:0]          cfg_data
);

    qasmm_pkg::cfg_t        cfg;
    qasmm_pkg::arm_status_t arm;

    logic item_xfer;
    logic out_open;
    logic s1_move;

    logic s1_valid_reg;
    logic s1_valid_next;
    logic out_valid_reg;
    logic out_valid_next;

    qasmm_pkg::item_t   s1_item_reg;
    logic signed [23:0] s1_adj_roll_reg;
    logic signed [23:0] s1_adj_pitch_reg;
    logic signed [24:0] prod_roll;
    logic signed [24:0] prod_pitch;

    qasmm_pkg::result_t out_reg;
    qasmm_pkg::result_t out_next;

    logic signed [19:0] sp_roll;
    logic signed [19:0] sp_pitch;
    logic signed [15:0] sp_yaw;
    logic [11:0]        esc_fr;
    logic [11:0]        esc_rr;
    logic [11:0]        esc_rl;
    logic [11:0]        esc_fl;

    qasmm_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Handshake and stage control.
    assign out_open   = !out_valid_reg || result.ready;
    assign s1_move    = s1_valid_reg && out_open;
    assign item.ready = !s1_valid_reg || out_open;
    assign item_xfer  = item.valid && item.ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (item_xfer)
            s1_valid_next = 1'b1;
        else if (s1_move)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (s1_move)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Level correction products; |angle * gain| stays below 2^23.
    assign prod_roll  = $signed(item.data.angle_roll_in) * $signed({1'b0, cfg.level_gain});
    assign prod_pitch = $signed(item.data.angle_pitch_in) * $signed({1'b0, cfg.level_gain});

    always_ff @(posedge clk)
    begin
        if (item_xfer)
        begin
            s1_item_reg      <= item.data;
            s1_adj_roll_reg  <= cfg.auto_level_on ? prod_roll[23:0] : '0;
            s1_adj_pitch_reg <= cfg.auto_level_on ? prod_pitch[23:0] : '0;
        end
    end

    qasmm_arming u_arming (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (s1_move && (s1_item_reg.func == qasmm_pkg::FUNC_SETPOINT)),
        .rx_throttle (s1_item_reg.rx_throttle),
        .rx_yaw      (s1_item_reg.rx_yaw),
        .status      (arm)
    );

    qasmm_setpoint u_setpoint (
        .rx_roll        (s1_item_reg.rx_roll),
        .rx_pitch       (s1_item_reg.rx_pitch),
        .rx_throttle    (s1_item_reg.rx_throttle),
        .rx_yaw         (s1_item_reg.rx_yaw),
        .adj_roll       (s1_adj_roll_reg),
        .adj_pitch      (s1_adj_pitch_reg),
        .setpoint_roll  (sp_roll),
        .setpoint_pitch (sp_pitch),
        .setpoint_yaw   (sp_yaw)
    );

    qasmm_mixer u_mixer (
        .cfg             (cfg),
        .running         (arm.current == qasmm_pkg::ARM_RUNNING),
        .rx_throttle     (s1_item_reg.rx_throttle),
        .pid_roll_out    (s1_item_reg.pid_roll_out),
        .pid_pitch_out   (s1_item_reg.pid_pitch_out),
        .pid_yaw_out     (s1_item_reg.pid_yaw_out),
        .esc_front_right (esc_fr),
        .esc_rear_right  (esc_rr),
        .esc_rear_left   (esc_rl),
        .esc_front_left  (esc_fl)
    );

    always_comb
    begin
        out_next = '0;
        unique case (s1_item_reg.func)
            qasmm_pkg::FUNC_SETPOINT:
            begin
                out_next.setpoint_roll  = sp_roll;
                out_next.setpoint_pitch = sp_pitch;
                out_next.setpoint_yaw   = sp_yaw;
                out_next.arm_state_out  = arm.updated;
                out_next.reset_request  = arm.armed;
            end
            qasmm_pkg::FUNC_MIX:
            begin
                out_next.arm_state_out   = arm.current;
                out_next.esc_front_right = esc_fr;
                out_next.esc_rear_right  = esc_rr;
                out_next.esc_rear_left   = esc_rl;
                out_next.esc_front_left  = esc_fl;
            end
            default: out_next = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
            out_reg <= out_next;
    end

    assign result.valid = out_valid_reg;
    assign result.data  = out_reg;

endmodule

>>> tb/sv/tb.sv
// Self-checking testbench for the quad arming, setpoint and motor mixer block.
`timescale 1ns / 1ps

module tb;
    import qasmm_pkg::*;

    localparam int CLK_PERIOD     = 20;
    localparam int RESET_CYCLES   = 4;
    localparam int MAX_GAP        = 9;
    localparam int HOLD_CYCLES    = 60;
    localparam int SETTLE_CYCLES  = 4;
    localparam int DRAIN_CYCLES   = 10;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SP_DIVISOR     = 3;

    localparam longint SP_RP_MIN  = -524288;
    localparam longint SP_RP_MAX  = 524287;
    localparam longint SP_YAW_MIN = -32768;
    localparam longint SP_YAW_MAX = 32767;

    // Indexes past the register list; writes to them must change nothing.
    localparam logic [2:0] CFG_SPARE_6 = 3'd6;
    localparam logic [2:0] CFG_SPARE_7 = 3'd7;

    typedef struct {
        item_t   it;
        bit      typed;
        result_t res;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wen;
    logic [2:0]  cfg_index;
    logic [11:0] cfg_data;

    qasmm_item_if   item_ch ();
    qasmm_result_if result_ch ();

    quad_arming_setpoint_motor_mixer uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_ch),
        .result    (result_ch),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Shadow of the block's configuration and arming state.
    cfg_t cfg_now = '{RST_AUTO_LEVEL_ON, RST_LEVEL_GAIN, RST_THROTTLE_CAP,
                      RST_ESC_RUN_MIN, RST_ESC_RUN_MAX, RST_ESC_OFF_PULSE};
    arm_state_t arm_now = ARM_STOPPED;

    result_t expected_results[$];
    int      n_err = 0;
    int      items_offered = 0;
    int      send_gap_max = MAX_GAP;
    int      recv_gap_max = MAX_GAP;
    int      holds_asked = 0;
    int      holds_given = 0;

    // Fixed expectation that travels with the item currently offered.
    bit      row_typed = 1'b0;
    result_t row_result = '0;

    function automatic longint stick_offset(logic [11:0] s);
        if (s > STICK_HI)
            return longint'(s) - longint'(STICK_HI);
        if (s < STICK_LO)
            return longint'(s) - longint'(STICK_LO);
        return 0;
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // The low clamp comes first, so the high clamp wins when the two cross.
    function automatic logic [11:0] esc_limit(longint v);
        longint x;
        x = v;
        if (x < longint'(cfg_now.esc_run_min))
            x = longint'(cfg_now.esc_run_min);
        if (x > longint'(cfg_now.esc_run_max))
            x = longint'(cfg_now.esc_run_max);
        return x[11:0];
    endfunction

    // Works out the result of one item and advances the arming shadow.
    function automatic result_t compute_result(item_t it);
        result_t r;
        longint  adj_r, adj_p, sr, sp, sy, base, pr, pp, py;
        bit      thr_low;
        r = '0;
        if (it.func == FUNC_SETPOINT)
        begin
            thr_low = it.rx_throttle < THR_LOW;
            if (thr_low && it.rx_yaw < YAW_PRIME)
                arm_now = ARM_PRIMED;
            if (arm_now == ARM_PRIMED && thr_low && it.rx_yaw > YAW_ARM)
            begin
                arm_now = ARM_RUNNING;
                r.reset_request = 1'b1;
            end
            if (arm_now == ARM_RUNNING && thr_low && it.rx_yaw > YAW_STOP)
                arm_now = ARM_STOPPED;
            adj_r = 0;
            adj_p = 0;
            if (cfg_now.auto_level_on)
            begin
                adj_r = longint'($signed(it.angle_roll_in)) * longint'(cfg_now.level_gain);
                adj_p = longint'($signed(it.angle_pitch_in)) * longint'(cfg_now.level_gain);
            end
            sr = (stick_offset(it.rx_roll) * 16 - adj_r) / SP_DIVISOR;
            sp = (-stick_offset(it.rx_pitch) * 16 - adj_p) / SP_DIVISOR;
            sy = 0;
            if (it.rx_throttle > THR_LOW)
                sy = (stick_offset(it.rx_yaw) * 16) / SP_DIVISOR;
            sr = clamp(sr, SP_RP_MIN, SP_RP_MAX);
            sp = clamp(sp, SP_RP_MIN, SP_RP_MAX);
            sy = clamp(sy, SP_YAW_MIN, SP_YAW_MAX);
            r.setpoint_roll  = sr[19:0];
            r.setpoint_pitch = sp[19:0];
            r.setpoint_yaw   = sy[15:0];
            r.arm_state_out  = arm_now;
        end
        else
        begin
            r.arm_state_out = arm_now;
            if (arm_now == ARM_RUNNING)
            begin
                pr = longint'($signed(it.pid_roll_out));
                pp = longint'($signed(it.pid_pitch_out));
                py = longint'($signed(it.pid_yaw_out));
                base = (it.rx_throttle > cfg_now.throttle_cap) ?
                       longint'(cfg_now.throttle_cap) : longint'(it.rx_throttle);
                r.esc_front_right = esc_limit(base - pp + pr - py);
                r.esc_rear_right  = esc_limit(base + pp + pr + py);
                r.esc_rear_left   = esc_limit(base + pp - pr - py);
                r.esc_front_left  = esc_limit(base - pp - pr + py);
            end
            else
            begin
                r.esc_front_right = cfg_now.esc_off_pulse;
                r.esc_rear_right  = cfg_now.esc_off_pulse;
                r.esc_rear_left   = cfg_now.esc_off_pulse;
                r.esc_front_left  = cfg_now.esc_off_pulse;
            end
        end
        return r;
    endfunction

    function automatic void check_field(string name, logic [19:0] want_v, logic [19:0] got_v);
        if (got_v !== want_v)
        begin
            $display("%0t: %s expected %0h, actual %0h", $time, name, want_v, got_v);
            n_err++;
        end
    endfunction

    function automatic item_t noise_item();
        logic [127:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom};
        return raw[$bits(item_t)-1:0];
    endfunction

    function automatic logic [11:0] stick_value();
        case ($urandom_range(0, 2))
            0: return 12'(STICK_LO - 4 + $urandom_range(0, 24));
            1: return 12'($urandom_range(1000, 2000));
            default: return 12'($urandom_range(0, 4095));
        endcase
    endfunction

    // Random item with throttle and yaw biased toward the arming thresholds.
    function automatic item_t random_item();
        item_t       it;
        logic [11:0] mark;
        it = noise_item();
        it.rx_roll  = stick_value();
        it.rx_pitch = stick_value();
        case ($urandom_range(0, 3))
            0: it.rx_throttle = 12'($urandom_range(0, THR_LOW - 1));
            1: it.rx_throttle = 12'(THR_LOW - 1 + $urandom_range(0, 2));
            2: it.rx_throttle = 12'($urandom_range(1000, 2200));
            default: ;
        endcase
        case ($urandom_range(0, 4))
            0: it.rx_yaw = 12'($urandom_range(0, YAW_PRIME - 1));
            1:
            begin
                case ($urandom_range(0, 2))
                    0: mark = YAW_PRIME;
                    1: mark = YAW_ARM;
                    default: mark = YAW_STOP;
                endcase
                it.rx_yaw = 12'(mark - 1 + $urandom_range(0, 2));
            end
            2: it.rx_yaw = 12'($urandom_range(YAW_ARM + 1, YAW_STOP));
            3: it.rx_yaw = 12'($urandom_range(YAW_STOP + 1, 4095));
            default: ;
        endcase
        if ($urandom_range(0, 1))
        begin
            it.angle_roll_in  = 16'(int'($urandom_range(0, 3200)) - 1600);
            it.angle_pitch_in = 16'(int'($urandom_range(0, 3200)) - 1600);
        end
        if ($urandom_range(0, 1))
        begin
            it.pid_roll_out  = 12'(int'($urandom_range(0, 600)) - 300);
            it.pid_pitch_out = 12'(int'($urandom_range(0, 600)) - 300);
            it.pid_yaw_out   = 12'(int'($urandom_range(0, 600)) - 300);
        end
        return it;
    endfunction

    function automatic item_t sp_item(logic [11:0] rr, logic [11:0] rp, logic [11:0] rt,
                                      logic [11:0] ry, logic signed [15:0] ar,
                                      logic signed [15:0] ap);
        item_t it;
        it = noise_item();
        it.func           = FUNC_SETPOINT;
        it.rx_roll        = rr;
        it.rx_pitch       = rp;
        it.rx_throttle    = rt;
        it.rx_yaw         = ry;
        it.angle_roll_in  = ar;
        it.angle_pitch_in = ap;
        return it;
    endfunction

    function automatic item_t mix_item(logic [11:0] rt, logic signed [11:0] pr,
                                       logic signed [11:0] pp, logic signed [11:0] py);
        item_t it;
        it = noise_item();
        it.func          = FUNC_MIX;
        it.rx_throttle   = rt;
        it.pid_roll_out  = pr;
        it.pid_pitch_out = pp;
        it.pid_yaw_out   = py;
        return it;
    endfunction

    // Setpoint result with centered sticks, level angles and no yaw term.
    function automatic result_t rest_result(arm_state_t a, logic armed);
        result_t r;
        r = '0;
        r.arm_state_out = a;
        r.reset_request = armed;
        return r;
    endfunction

    function automatic result_t esc_result(arm_state_t a, logic [11:0] p);
        result_t r;
        r = '0;
        r.arm_state_out   = a;
        r.esc_front_right = p;
        r.esc_rear_right  = p;
        r.esc_rear_left   = p;
        r.esc_front_left  = p;
        return r;
    endfunction

    task automatic offer(input item_t it, input bit typed, input result_t res);
        int gap;
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.data  <= it;
        row_typed     <= typed;
        row_result    <= res;
        @(posedge clk);
        while (item_ch.ready !== 1'b1)
            @(posedge clk);
        items_offered++;
    endtask

    task automatic drain();
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_config(input cfg_t c);
        logic [11:0] junk;
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        junk = 12'($urandom);
        cfg_wen   <= 1'b1;
        cfg_index <= CFG_AUTO_LEVEL_ON;
        cfg_data  <= {junk[11:1], c.auto_level_on};
        @(posedge clk);
        cfg_index <= CFG_LEVEL_GAIN;
        cfg_data  <= {junk[11:8], c.level_gain};
        @(posedge clk);
        cfg_index <= CFG_THROTTLE_CAP;
        cfg_data  <= c.throttle_cap;
        @(posedge clk);
        cfg_index <= CFG_ESC_RUN_MIN;
        cfg_data  <= c.esc_run_min;
        @(posedge clk);
        cfg_index <= CFG_ESC_RUN_MAX;
        cfg_data  <= c.esc_run_max;
        @(posedge clk);
        cfg_index <= CFG_ESC_OFF_PULSE;
        cfg_data  <= c.esc_off_pulse;
        @(posedge clk);
        cfg_index <= CFG_SPARE_6;
        cfg_data  <= 12'($urandom);
        @(posedge clk);
        cfg_index <= CFG_SPARE_7;
        cfg_data  <= 12'($urandom);
        @(posedge clk);
        cfg_wen <= 1'b0;
    endtask

    // Prime, arm, then fly a few mix items with live PID content.
    task automatic arming_sequence();
        item_t it;
        it = random_item();
        it.func        = FUNC_SETPOINT;
        it.rx_throttle = 12'($urandom_range(0, THR_LOW - 1));
        it.rx_yaw      = 12'($urandom_range(0, YAW_PRIME - 1));
        offer(it, 1'b0, '0);
        it = random_item();
        it.func        = FUNC_SETPOINT;
        it.rx_throttle = 12'($urandom_range(0, THR_LOW - 1));
        it.rx_yaw      = 12'($urandom_range(YAW_ARM + 1, YAW_STOP));
        offer(it, 1'b0, '0);
        repeat ($urandom_range(2, 8))
        begin
            it = random_item();
            it.func        = FUNC_MIX;
            it.rx_throttle = 12'($urandom_range(900, 2200));
            offer(it, 1'b0, '0);
        end
    endtask

    task automatic random_phase(input int count);
        int goal;
        goal = items_offered + count;
        while (items_offered < goal)
        begin
            // Switch now and then between idling sides and full-rate stretches.
            if ($urandom_range(0, 19) == 0)
            begin
                send_gap_max = ($urandom_range(0, 2) == 0) ? 0 : MAX_GAP;
                recv_gap_max = ($urandom_range(0, 2) == 0) ? 0 : MAX_GAP;
            end
            case ($urandom_range(0, 9))
                0: arming_sequence();
                1: offer(noise_item(), 1'b0, '0);
                2:
                begin
                    if ($urandom_range(0, 3) == 0)
                        drain();
                    offer(random_item(), 1'b0, '0);
                end
                default: offer(random_item(), 1'b0, '0);
            endcase
        end
    endtask

    always @(posedge clk)
    begin : scoreboard
        result_t want;
        if (rst_n)
        begin
            if (cfg_wen === 1'b1)
            begin
                case (cfg_index)
                    CFG_AUTO_LEVEL_ON: cfg_now.auto_level_on = cfg_data[0];
                    CFG_LEVEL_GAIN:    cfg_now.level_gain    = cfg_data[7:0];
                    CFG_THROTTLE_CAP:  cfg_now.throttle_cap  = cfg_data;
                    CFG_ESC_RUN_MIN:   cfg_now.esc_run_min   = cfg_data;
                    CFG_ESC_RUN_MAX:   cfg_now.esc_run_max   = cfg_data;
                    CFG_ESC_OFF_PULSE: cfg_now.esc_off_pulse = cfg_data;
                    default: ;
                endcase
            end
            if (item_ch.valid === 1'b1 && item_ch.ready === 1'b1)
            begin
                want = compute_result(item_ch.data);
                expected_results.push_back(row_typed ? row_result : want);
            end
            if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result transfer with nothing expected, actual %p",
                             $time, result_ch.data);
                    n_err++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("setpoint_roll", want.setpoint_roll,
                                result_ch.data.setpoint_roll);
                    check_field("setpoint_pitch", want.setpoint_pitch,
                                result_ch.data.setpoint_pitch);
                    check_field("setpoint_yaw", want.setpoint_yaw,
                                result_ch.data.setpoint_yaw);
                    check_field("arm_state_out", want.arm_state_out,
                                result_ch.data.arm_state_out);
                    check_field("reset_request", want.reset_request,
                                result_ch.data.reset_request);
                    check_field("esc_front_right", want.esc_front_right,
                                result_ch.data.esc_front_right);
                    check_field("esc_rear_right", want.esc_rear_right,
                                result_ch.data.esc_rear_right);
                    check_field("esc_rear_left", want.esc_rear_left,
                                result_ch.data.esc_rear_left);
                    check_field("esc_front_left", want.esc_front_left,
                                result_ch.data.esc_front_left);
                end
            end
        end
    end

    initial
    begin : result_sink
        int wait_n;
        result_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (holds_given < holds_asked)
            begin
                wait_n = HOLD_CYCLES;
                holds_given++;
            end
            else
                wait_n = $urandom_range(0, recv_gap_max);
            if (wait_n > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (wait_n) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            @(posedge clk);
            while (result_ch.valid !== 1'b1)
                @(posedge clk);
        end
    end

    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        wait (rst_n === 1'b1);
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((item_ch.valid === 1'b1 && item_ch.ready === 1'b1) ||
                (result_ch.valid === 1'b1 && result_ch.ready === 1'b1))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin : stimulus
        stim_row_t stim_rows[$];
        cfg_t      c;
        item_ch.valid = 1'b0;
        item_ch.data  = '0;
        cfg_wen       = 1'b0;
        cfg_index     = CFG_AUTO_LEVEL_ON;
        cfg_data      = '0;

        // Directed rows run on the reset configuration.
        stim_rows.push_back('{mix_item(1500, 0, 0, 0), 1'b1,
                              esc_result(ARM_STOPPED, RST_ESC_OFF_PULSE)});
        stim_rows.push_back('{sp_item(1500, 1500, 1100, 1500, 0, 0), 1'b1,
                              rest_result(ARM_STOPPED, 1'b0)});
        stim_rows.push_back('{sp_item(4095, 4095, 4095, 4095, 32767, 32767), 1'b0, '0});
        stim_rows.push_back('{sp_item(0, 0, 0, 0, -32768, -32768), 1'b0, '0});
        stim_rows.push_back('{sp_item(1508, 1492, 1051, 1508, 0, 0), 1'b1,
                              rest_result(ARM_PRIMED, 1'b0)});
        // Odd stick offsets exercise truncation of the division toward zero.
        stim_rows.push_back('{sp_item(1509, 1491, 1050, 1509, 1, -1), 1'b0, '0});
        stim_rows.push_back('{mix_item(4095, 2047, 2047, 2047), 1'b1,
                              esc_result(ARM_PRIMED, RST_ESC_OFF_PULSE)});
        stim_rows.push_back('{sp_item(1500, 1500, 1049, 1300, 0, 0), 1'b1,
                              rest_result(ARM_PRIMED, 1'b0)});
        stim_rows.push_back('{sp_item(1500, 1500, 1049, 1450, 0, 0), 1'b1,
                              rest_result(ARM_PRIMED, 1'b0)});
        stim_rows.push_back('{sp_item(1500, 1500, 1049, 1451, 0, 0), 1'b1,
                              rest_result(ARM_RUNNING, 1'b1)});
        stim_rows.push_back('{mix_item(1500, 0, 0, 0), 1'b1,
                              esc_result(ARM_RUNNING, 1500)});
        stim_rows.push_back('{mix_item(4095, 2047, 2047, 2047), 1'b0, '0});
        stim_rows.push_back('{mix_item(0, -2048, -2048, -2048), 1'b0, '0});
        stim_rows.push_back('{mix_item(1500, 100, -50, 25), 1'b0, '0});
        stim_rows.push_back('{sp_item(1500, 1500, 1049, 1700, 160, -160), 1'b0, '0});
        stim_rows.push_back('{sp_item(1500, 1500, 1049, 1701, 0, 0), 1'b1,
                              rest_result(ARM_STOPPED, 1'b0)});
        stim_rows.push_back('{mix_item(2000, 0, 0, 0), 1'b1,
                              esc_result(ARM_STOPPED, RST_ESC_OFF_PULSE)});
        stim_rows.push_back('{sp_item(1500, 1500, 1000, 1299, 0, 0), 1'b1,
                              rest_result(ARM_PRIMED, 1'b0)});
        // A primed machine that sees a full yaw stick arms and stops at once.
        stim_rows.push_back('{sp_item(1500, 1500, 1000, 4095, 0, 0), 1'b1,
                              rest_result(ARM_STOPPED, 1'b1)});
        stim_rows.push_back('{sp_item(1500, 1500, 0, 0, 0, 0), 1'b1,
                              rest_result(ARM_PRIMED, 1'b0)});
        stim_rows.push_back('{sp_item(1500, 1500, 0, 1600, 0, 0), 1'b1,
                              rest_result(ARM_RUNNING, 1'b1)});
        stim_rows.push_back('{sp_item(1500, 1500, 1000, 1000, 0, 0), 1'b1,
                              rest_result(ARM_PRIMED, 1'b0)});
        stim_rows.push_back('{sp_item(4095, 0, 1051, 0, 0, 0), 1'b0, '0});
        stim_rows.push_back('{sp_item(1500, 1500, 1051, 1500, -32768, 32767), 1'b0, '0});

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_rows[i])
            offer(stim_rows[i].it, stim_rows[i].typed, stim_rows[i].res);

        random_phase(30);
        // Long receiver stall while the sender keeps offering at full rate.
        holds_asked++;
        send_gap_max = 0;
        repeat (20) offer(random_item(), 1'b0, '0);
        send_gap_max = MAX_GAP;
        random_phase(40);

        c = '{1'b1, 8'd255, 12'd4095, 12'd0, 12'd4095, 12'd4095};
        write_config(c);
        random_phase(70);

        c = '{1'b0, 8'd0, 12'd0, 12'd4095, 12'd0, 12'd0};
        write_config(c);
        random_phase(60);

        repeat (2)
        begin
            c.auto_level_on = 1'($urandom);
            c.level_gain    = 8'($urandom_range(0, 40));
            c.throttle_cap  = 12'($urandom_range(1500, 2000));
            c.esc_run_min   = 12'($urandom_range(1000, 1200));
            c.esc_run_max   = 12'($urandom_range(1800, 2100));
            c.esc_off_pulse = 12'($urandom_range(900, 1100));
            write_config(c);
            random_phase(50);
        end

        c.auto_level_on = 1'($urandom);
        c.level_gain    = 8'($urandom);
        c.throttle_cap  = 12'($urandom);
        c.esc_run_min   = 12'($urandom);
        c.esc_run_max   = 12'($urandom);
        c.esc_off_pulse = 12'($urandom);
        write_config(c);
        random_phase(60);

        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (n_err == 0 && expected_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> files.f
hdl/qasmm_pkg.sv
hdl/qasmm_if.sv
hdl/qasmm_cfg_regs.sv
hdl/qasmm_arming.sv
hdl/qasmm_setpoint.sv
hdl/qasmm_mixer.sv
hdl/quad_arming_setpoint_motor_mixer.sv
tb/sv/tb.sv
